>>> sv/hextile_tile_stream_decoder_macros.svh
// Assertion macros shared by the hextile tile stream decoder RTL.
`ifndef HEXTILE_TILE_STREAM_DECODER_MACROS_SVH
`define HEXTILE_TILE_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define HTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hextile decoder check failed");
// Clocked check that also holds during reset.
`define HTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hextile decoder check failed");
`else
`define HTS_ASSERT(lbl, clk, rst_n, prop)
`define HTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/hts_pkg.sv
// Shared types and constants of the hextile tile stream decoder.
package hts_pkg;

  localparam int TILE_EDGE   = 16;
  localparam int MAX_FRAME   = 4096;
  localparam int TILE_BITS   = $clog2(TILE_EDGE);
  localparam int COORD_W     = 13;
  localparam int EDGE_W      = 12;
  localparam int SIZE_W      = 5;
  localparam int COLOR_W     = 32;
  localparam int BPP_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int NUM_REGS    = 7;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Tile flag bits in the flags byte
  localparam int FLAG_RAW     = 0;
  localparam int FLAG_BG      = 1;
  localparam int FLAG_FG      = 2;
  localparam int FLAG_ANYSUB  = 3;
  localparam int FLAG_COLORED = 4;

  // Bit positions of the kept flags (foreground, any subrects, colored)
  localparam int KF_FG      = 0;
  localparam int KF_ANYSUB  = 1;
  localparam int KF_COLORED = 2;

  // Register reset values
  localparam logic [BPP_W-1:0]   BPP_RST      = BPP_W'(4);
  localparam logic [COORD_W-1:0] FRAME_W_RST  = COORD_W'(1024);
  localparam logic [COORD_W-1:0] FRAME_H_RST  = COORD_W'(768);
  localparam logic [EDGE_W-1:0]  RECT_L_RST   = '0;
  localparam logic [EDGE_W-1:0]  RECT_T_RST   = '0;
  localparam logic [COORD_W-1:0] RECT_R_RST   = COORD_W'(16);
  localparam logic [COORD_W-1:0] RECT_B_RST   = COORD_W'(16);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BPP      = 3'd0,
    REG_FRAME_W  = 3'd1,
    REG_FRAME_H  = 3'd2,
    REG_RECT_L   = 3'd3,
    REG_RECT_T   = 3'd4,
    REG_RECT_R   = 3'd5,
    REG_RECT_B   = 3'd6
  } hts_reg_e;

  typedef enum logic [3:0] {
    PH_FLAGS  = 4'd0,
    PH_RAW    = 4'd1,
    PH_BG     = 4'd2,
    PH_FG     = 4'd3,
    PH_COUNT  = 4'd4,
    PH_SUBCOL = 4'd5,
    PH_SUBXY  = 4'd6,
    PH_SUBWH  = 4'd7,
    PH_STOP   = 4'd8
  } hts_phase_e;

  typedef enum logic [2:0] {
    KIND_FILL    = 3'd0,
    KIND_PIXEL   = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_OUTSIDE = 3'd3,
    KIND_NO_BG   = 3'd4
  } hts_kind_e;

  // Command from the parser: tile origin plus an in-tile offset
  typedef struct packed {
    hts_kind_e              kind;
    logic [COORD_W-1:0]     base_x;
    logic [COORD_W-1:0]     base_y;
    logic [TILE_BITS-1:0]   off_x;
    logic [TILE_BITS-1:0]   off_y;
    logic [SIZE_W-1:0]      width;
    logic [SIZE_W-1:0]      height;
    logic [COLOR_W-1:0]     color;
    logic                   last;
  } hts_cmd_t;

  // Finished result as shown on the ports
  typedef struct packed {
    hts_kind_e              kind;
    logic [COORD_W-1:0]     pos_x;
    logic [COORD_W-1:0]     pos_y;
    logic [SIZE_W-1:0]      width;
    logic [SIZE_W-1:0]      height;
    logic [COLOR_W-1:0]     color;
    logic                   last;
  } hts_res_t;

endpackage

>>> sv/hts_parser.sv
// Front end: configuration registers and the per-byte tile stream parser.
module hts_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_valid_i,
  input  logic [hts_pkg::BYTE_W-1:0]    byte_i,
  input  logic                          cfg_we_i,
  input  logic [hts_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hts_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                          cmd_valid_o,
  output hts_pkg::hts_cmd_t             cmd_o,
  output logic                          stopped_o
);
  import hts_pkg::*;

  // Configuration registers
  logic [BPP_W-1:0]   bpp_q;
  logic [COORD_W-1:0] frame_w_q, frame_h_q;
  logic [EDGE_W-1:0]  rect_l_q, rect_t_q;
  logic [COORD_W-1:0] rect_r_q, rect_b_q;

  // Parser state
  hts_phase_e           phase_q, phase_d;
  logic [COORD_W-1:0]   tile_x_q, tile_x_d, tile_y_q, tile_y_d;
  logic [SIZE_W-1:0]    tile_w_q, tile_w_d, tile_h_q, tile_h_d;
  logic [2:0]           flags_q, flags_d;
  logic [COLOR_W-1:0]   bg_q, bg_d, fg_q, fg_d, acc_q, acc_d;
  logic                 bg_seen_q, bg_seen_d;
  logic [1:0]           idx_q, idx_d;
  logic [TILE_BITS-1:0] raw_col_q, raw_col_d, raw_row_q, raw_row_d;
  logic [BYTE_W-1:0]    subs_q, subs_d, sub_xy_q, sub_xy_d;

  logic                 cfg_hit;
  logic [EDGE_W-1:0]    arm_l, arm_t;
  logic [COORD_W:0]     tx_inc, ty_inc, r_x, r_y;
  logic [COORD_W-1:0]   fw_sat, fh_sat;
  logic                 empty_rect, outside, wrap_x, last_row;
  logic [1:0]           bpp_m1;
  logic [COLOR_W-1:0]   acc_next;
  logic                 pix_done;
  logic [2:0]           flags_eff;
  logic                 emit, go_after_bg, go_after_fg, go_end;
  hts_cmd_t             cmd;

  assign cfg_hit = cfg_we_i && (int'(cfg_addr_i) < NUM_REGS);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q     <= BPP_RST;
      frame_w_q <= FRAME_W_RST;
      frame_h_q <= FRAME_H_RST;
      rect_l_q  <= RECT_L_RST;
      rect_t_q  <= RECT_T_RST;
      rect_r_q  <= RECT_R_RST;
      rect_b_q  <= RECT_B_RST;
    end else if (cfg_we_i) begin
      case (hts_reg_e'(cfg_addr_i))
        REG_BPP:     bpp_q     <= cfg_wdata_i[BPP_W-1:0];
        REG_FRAME_W: frame_w_q <= cfg_wdata_i;
        REG_FRAME_H: frame_h_q <= cfg_wdata_i;
        REG_RECT_L:  rect_l_q  <= cfg_wdata_i[EDGE_W-1:0];
        REG_RECT_T:  rect_t_q  <= cfg_wdata_i[EDGE_W-1:0];
        REG_RECT_R:  rect_r_q  <= cfg_wdata_i;
        REG_RECT_B:  rect_b_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Rearm from the freshly written rectangle origin
  assign arm_l = (hts_reg_e'(cfg_addr_i) == REG_RECT_L) ? cfg_wdata_i[EDGE_W-1:0] : rect_l_q;
  assign arm_t = (hts_reg_e'(cfg_addr_i) == REG_RECT_T) ? cfg_wdata_i[EDGE_W-1:0] : rect_t_q;

  // Tile geometry, clipped at the rectangle edges
  assign tx_inc = {1'b0, tile_x_q} + (COORD_W+1)'(TILE_EDGE);
  assign ty_inc = {1'b0, tile_y_q} + (COORD_W+1)'(TILE_EDGE);
  assign r_x    = (tx_inc > {1'b0, rect_r_q}) ? {1'b0, rect_r_q} : tx_inc;
  assign r_y    = (ty_inc > {1'b0, rect_b_q}) ? {1'b0, rect_b_q} : ty_inc;
  assign fw_sat = (frame_w_q > COORD_W'(MAX_FRAME)) ? COORD_W'(MAX_FRAME) : frame_w_q;
  assign fh_sat = (frame_h_q > COORD_W'(MAX_FRAME)) ? COORD_W'(MAX_FRAME) : frame_h_q;
  assign outside  = (r_x > {1'b0, fw_sat}) || (r_y > {1'b0, fh_sat});
  assign empty_rect = ({1'b0, rect_l_q} >= rect_r_q) || ({1'b0, rect_t_q} >= rect_b_q);
  assign wrap_x   = tx_inc >= {1'b0, rect_r_q};
  assign last_row = ty_inc >= {1'b0, rect_b_q};

  // Pixel assembly, first byte lowest
  always_comb begin
    if (bpp_q == '0) begin
      bpp_m1 = 2'd0;
    end else if (bpp_q > BPP_W'(4)) begin
      bpp_m1 = 2'd3;
    end else begin
      bpp_m1 = 2'(bpp_q - BPP_W'(1));
    end
  end
  assign acc_next = acc_q | (COLOR_W'(byte_i) << {idx_q, 3'b000});
  assign pix_done = (idx_q == bpp_m1);

  assign flags_eff = (phase_q == PH_FLAGS) ?
                     {byte_i[FLAG_COLORED], byte_i[FLAG_ANYSUB], byte_i[FLAG_FG]} : flags_q;

  // Next state and command for one byte
  always_comb begin
    phase_d     = phase_q;
    tile_x_d    = tile_x_q;
    tile_y_d    = tile_y_q;
    tile_w_d    = tile_w_q;
    tile_h_d    = tile_h_q;
    flags_d     = flags_q;
    bg_d        = bg_q;
    fg_d        = fg_q;
    bg_seen_d   = bg_seen_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    raw_col_d   = raw_col_q;
    raw_row_d   = raw_row_q;
    subs_d      = subs_q;
    sub_xy_d    = sub_xy_q;
    emit        = 1'b0;
    go_after_bg = 1'b0;
    go_after_fg = 1'b0;
    go_end      = 1'b0;
    cmd         = '0;
    cmd.kind    = KIND_FILL;
    cmd.base_x  = tile_x_q;
    cmd.base_y  = tile_y_q;

    // Advance the pixel accumulator in the pixel-reading phases
    if ((phase_q == PH_RAW) || (phase_q == PH_BG) || (phase_q == PH_FG) ||
        (phase_q == PH_SUBCOL)) begin
      acc_d = pix_done ? '0 : acc_next;
      idx_d = pix_done ? 2'd0 : 2'(idx_q + 2'd1);
    end

    case (phase_q)
      PH_FLAGS: begin
        tile_w_d = SIZE_W'(r_x - {1'b0, tile_x_q});
        tile_h_d = SIZE_W'(r_y - {1'b0, tile_y_q});
        if (empty_rect) begin
          phase_d   = PH_STOP;
          emit      = 1'b1;
          cmd       = '0;
          cmd.kind  = KIND_DONE;
          cmd.last  = 1'b1;
        end else if (outside) begin
          phase_d    = PH_STOP;
          emit       = 1'b1;
          cmd.kind   = KIND_OUTSIDE;
          cmd.width  = tile_w_d;
          cmd.height = tile_h_d;
          cmd.last   = 1'b1;
        end else begin
          flags_d = flags_eff;
          acc_d   = '0;
          idx_d   = 2'd0;
          if (byte_i[FLAG_RAW]) begin
            raw_col_d = '0;
            raw_row_d = '0;
            phase_d   = PH_RAW;
          end else if (byte_i[FLAG_BG]) begin
            phase_d = PH_BG;
          end else begin
            if (bg_seen_q) begin
              emit       = 1'b1;
              cmd.width  = tile_w_d;
              cmd.height = tile_h_d;
              cmd.color  = bg_q;
            end
            go_after_bg = 1'b1;
          end
        end
      end
      PH_RAW: begin
        if (pix_done) begin
          emit       = 1'b1;
          cmd.kind   = KIND_PIXEL;
          cmd.off_x  = raw_col_q;
          cmd.off_y  = raw_row_q;
          cmd.width  = SIZE_W'(1);
          cmd.height = SIZE_W'(1);
          cmd.color  = acc_next;
          if (({1'b0, raw_col_q} + SIZE_W'(1)) >= tile_w_q) begin
            raw_col_d = '0;
            raw_row_d = raw_row_q + TILE_BITS'(1);
            if (({1'b0, raw_row_q} + SIZE_W'(1)) >= tile_h_q) begin
              go_end = 1'b1;
            end
          end else begin
            raw_col_d = raw_col_q + TILE_BITS'(1);
          end
        end
      end
      PH_BG: begin
        if (pix_done) begin
          bg_d        = acc_next;
          bg_seen_d   = 1'b1;
          emit        = 1'b1;
          cmd.width   = tile_w_q;
          cmd.height  = tile_h_q;
          cmd.color   = acc_next;
          go_after_bg = 1'b1;
        end
      end
      PH_FG: begin
        if (pix_done) begin
          fg_d        = acc_next;
          go_after_fg = 1'b1;
        end
      end
      PH_COUNT: begin
        subs_d = byte_i;
        if (byte_i == '0) begin
          go_end = 1'b1;
        end else begin
          phase_d = (flags_eff[KF_COLORED] && !flags_eff[KF_FG]) ? PH_SUBCOL : PH_SUBXY;
        end
      end
      PH_SUBCOL: begin
        if (pix_done) begin
          fg_d    = acc_next;
          phase_d = PH_SUBXY;
        end
      end
      PH_SUBXY: begin
        sub_xy_d = byte_i;
        phase_d  = PH_SUBWH;
      end
      PH_SUBWH: begin
        emit       = 1'b1;
        cmd.off_x  = sub_xy_q[7:4];
        cmd.off_y  = sub_xy_q[3:0];
        cmd.width  = {1'b0, byte_i[7:4]} + SIZE_W'(1);
        cmd.height = {1'b0, byte_i[3:0]} + SIZE_W'(1);
        cmd.color  = fg_q;
        subs_d     = subs_q - BYTE_W'(1);
        if (subs_q == BYTE_W'(1)) begin
          go_end = 1'b1;
        end else begin
          phase_d = (flags_eff[KF_COLORED] && !flags_eff[KF_FG]) ? PH_SUBCOL : PH_SUBXY;
        end
      end
      PH_STOP: ;
      default: ;
    endcase

    // After the background: foreground color, or go on
    if (go_after_bg) begin
      if (flags_eff[KF_FG]) begin
        phase_d = PH_FG;
      end else begin
        go_after_fg = 1'b1;
      end
    end

    // After the foreground: subrectangle count, error, or tile end
    if (go_after_fg) begin
      if (flags_eff[KF_ANYSUB]) begin
        phase_d = PH_COUNT;
      end else if (!bg_seen_d) begin
        phase_d    = PH_STOP;
        emit       = 1'b1;
        cmd        = '0;
        cmd.kind   = KIND_NO_BG;
        cmd.base_x = tile_x_q;
        cmd.base_y = tile_y_q;
        cmd.width  = tile_w_d;
        cmd.height = tile_h_d;
        cmd.last   = 1'b1;
      end else begin
        go_end = 1'b1;
      end
    end

    // Step to the next tile; mark the end of the rectangle
    if (go_end) begin
      phase_d  = PH_FLAGS;
      tile_x_d = tx_inc[COORD_W-1:0];
      if (wrap_x) begin
        tile_x_d = COORD_W'(rect_l_q);
        tile_y_d = ty_inc[COORD_W-1:0];
        if (last_row) begin
          phase_d = PH_STOP;
          if (emit) begin
            cmd.last = 1'b1;
          end else begin
            emit     = 1'b1;
            cmd      = '0;
            cmd.kind = KIND_DONE;
            cmd.last = 1'b1;
          end
        end
      end
    end
  end

  // Parser state: rearm on a register write, advance on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FLAGS;
      tile_x_q  <= COORD_W'(RECT_L_RST);
      tile_y_q  <= COORD_W'(RECT_T_RST);
      tile_w_q  <= '0;
      tile_h_q  <= '0;
      flags_q   <= '0;
      bg_q      <= '0;
      fg_q      <= '0;
      bg_seen_q <= 1'b0;
      acc_q     <= '0;
      idx_q     <= '0;
      raw_col_q <= '0;
      raw_row_q <= '0;
      subs_q    <= '0;
      sub_xy_q  <= '0;
    end else if (cfg_hit) begin
      phase_q   <= PH_FLAGS;
      tile_x_q  <= COORD_W'(arm_l);
      tile_y_q  <= COORD_W'(arm_t);
      tile_w_q  <= '0;
      tile_h_q  <= '0;
      flags_q   <= '0;
      bg_q      <= '0;
      fg_q      <= '0;
      bg_seen_q <= 1'b0;
      acc_q     <= '0;
      idx_q     <= '0;
      raw_col_q <= '0;
      raw_row_q <= '0;
      subs_q    <= '0;
      sub_xy_q  <= '0;
    end else if (byte_valid_i) begin
      phase_q   <= phase_d;
      tile_x_q  <= tile_x_d;
      tile_y_q  <= tile_y_d;
      tile_w_q  <= tile_w_d;
      tile_h_q  <= tile_h_d;
      flags_q   <= flags_d;
      bg_q      <= bg_d;
      fg_q      <= fg_d;
      bg_seen_q <= bg_seen_d;
      acc_q     <= acc_d;
      idx_q     <= idx_d;
      raw_col_q <= raw_col_d;
      raw_row_q <= raw_row_d;
      subs_q    <= subs_d;
      sub_xy_q  <= sub_xy_d;
    end
  end

  assign cmd_valid_o = byte_valid_i && emit;
  assign cmd_o       = cmd;
  assign stopped_o   = (phase_q == PH_STOP);

endmodule

>>> sv/hts_cmd_fifo.sv
// Command queue between the parser and the result stage.
module hts_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hts_pkg::hts_cmd_t  data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output hts_pkg::hts_cmd_t  data_o
);
  import hts_pkg::*;

  hts_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store an entry on each push transfer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

>>> sv/hts_exec.sv
// Back end: resolves absolute positions and holds the result register.
module hts_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  hts_pkg::hts_cmd_t  cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output hts_pkg::hts_res_t  res_o,
  input  logic               res_pop_i
);
  import hts_pkg::*;

  logic     valid_q;
  hts_res_t res_q, res_d;
  logic     load;

  // Take a command when the result register is free or being drained
  assign load      = cmd_valid_i && (!valid_q || res_pop_i);
  assign cmd_pop_o = load;

  // Add the in-tile offset to the tile origin, wrapping at the coordinate width
  always_comb begin
    res_d.kind   = cmd_i.kind;
    res_d.pos_x  = cmd_i.base_x + COORD_W'(cmd_i.off_x);
    res_d.pos_y  = cmd_i.base_y + COORD_W'(cmd_i.off_y);
    res_d.width  = cmd_i.width;
    res_d.height = cmd_i.height;
    res_d.color  = cmd_i.color;
    res_d.last   = cmd_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (res_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> sv/hextile_tile_stream_decoder.sv
// Hextile tile stream decoder: takes one encoded byte per cycle while full
// is low and returns drawing commands (fills, put-pixels, done and error
// marks) through a queue interface on both sides. The block sustains one
// byte and one result per clock while neither side stalls; a command is
// registered in the command queue and then in the output register before it
// reaches the ports. Results wait in a four-entry command queue followed by one
// output register, and full rises only when all four queue entries are
// occupied, so up to five results may be pending while the consumer stalls.
// Writing any register rearms the decoder for a new rectangle; after an
// error or the last tile, bytes are dropped until the next register write.
// No clearing pass is needed after reset.
`include "hextile_tile_stream_decoder_macros.svh"
module hextile_tile_stream_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [hts_pkg::BYTE_W-1:0]      stream_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      kind_o,
  output logic [hts_pkg::COORD_W-1:0]     pos_x_o,
  output logic [hts_pkg::COORD_W-1:0]     pos_y_o,
  output logic [hts_pkg::SIZE_W-1:0]      fill_width_o,
  output logic [hts_pkg::SIZE_W-1:0]      fill_height_o,
  output logic [hts_pkg::COLOR_W-1:0]     color_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic [hts_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import hts_pkg::*;

  logic     byte_accept;
  logic     cmd_valid, q_full, q_valid, q_pop, stopped;
  logic     res_valid;
  logic     res_term;
  hts_cmd_t cmd, q_cmd;
  hts_res_t res;

  assign byte_accept = push && !q_full;
  assign full        = q_full;

  // Front end: parse and classify bytes
  hts_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_accept),
    .byte_i       (stream_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .stopped_o    (stopped)
  );

  // Decouple front and back
  hts_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  // Back end: position resolve and result register
  hts_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty         = !res_valid;
  assign kind_o        = res.kind;
  assign pos_x_o       = res.pos_x;
  assign pos_y_o       = res.pos_y;
  assign fill_width_o  = res.width;
  assign fill_height_o = res.height;
  assign color_o       = res.color;
  assign last_o        = res.last;

  // Flag a waiting done or error result
  assign res_term = res_valid && (res.kind inside {KIND_DONE, KIND_OUTSIDE, KIND_NO_BG});

  // Commands only arrive when the queue has room
  `HTS_ASSERT_ALWAYS(a_no_overflow, clk_i, cmd_valid |-> !q_full)
  // A stopped parser drops bytes without producing commands
  `HTS_ASSERT(a_stop_silent, clk_i, rst_ni, (byte_accept && stopped) |-> !cmd_valid)
  // A register write rearms the parser
  `HTS_ASSERT(a_rearm, clk_i, rst_ni, (cfg_we_i && (int'(cfg_addr_i) < NUM_REGS)) |=> !stopped)
  // Done and error results always close the rectangle
  `HTS_ASSERT_ALWAYS(a_term_last, clk_i, res_term |-> res.last)

endmodule

>>> tb/hextile_tile_stream_decoder_tb.sv
// Self-checking testbench for the hextile tile stream decoder.
module hextile_tile_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hts_pkg::*;

  localparam int          SETTLE_CYCLES = 4;
  localparam int          RANDOM_BYTES  = 1450;
  localparam int          TIMEOUT_NS    = 1_000_000;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef logic [BYTE_W-1:0] byte_list_t[$];

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [BYTE_W-1:0]     stream_byte_i;
  logic                  empty;
  logic                  pop;
  logic [2:0]            kind_o;
  logic [COORD_W-1:0]    pos_x_o;
  logic [COORD_W-1:0]    pos_y_o;
  logic [SIZE_W-1:0]     fill_width_o;
  logic [SIZE_W-1:0]     fill_height_o;
  logic [COLOR_W-1:0]    color_o;
  logic                  last_o;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  hextile_tile_stream_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .stream_byte_i (stream_byte_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .fill_width_o  (fill_width_o),
    .fill_height_o (fill_height_o),
    .color_o       (color_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Mirrored registers
  logic [BPP_W-1:0] cfg_bpp;
  int unsigned      cfg_frame_w, cfg_frame_h;
  int unsigned      cfg_left, cfg_top, cfg_right, cfg_bottom;

  // Mirrored decoder state
  hts_phase_e       phase;
  int unsigned      tile_x, tile_y, tile_w, tile_h;
  logic [7:0]       tile_flags;
  logic [31:0]      background, foreground;
  bit               bg_seen;
  logic [31:0]      pix_acc;
  int unsigned      pix_cnt;
  int unsigned      raw_col, raw_row;
  int unsigned      subs_left;
  logic [7:0]       sub_xy;

  // Command built for the current byte
  bit               got;
  hts_res_t         cmd;

  hts_res_t         pending_cmds[$];
  int               err_cnt;
  int               kind_hits[8];
  int               rect_cnt;
  int               byte_cnt;
  bit               idle_on;
  int               rx_hold_len;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror
  // ---------------------------------------------------------------------------

  function automatic void rearm();
    phase      = PH_FLAGS;
    tile_x     = cfg_left;
    tile_y     = cfg_top;
    tile_w     = 0;
    tile_h     = 0;
    tile_flags = '0;
    background = '0;
    foreground = '0;
    bg_seen    = 1'b0;
    pix_acc    = '0;
    pix_cnt    = 0;
    raw_col    = 0;
    raw_row    = 0;
    subs_left  = 0;
    sub_xy     = '0;
  endfunction

  function automatic void clear_pixel();
    pix_acc = '0;
    pix_cnt = 0;
  endfunction

  function automatic int unsigned frame_cap(int unsigned v);
    return (v > MAX_FRAME) ? MAX_FRAME : v;
  endfunction

  function automatic void emit_cmd(hts_kind_e k, int unsigned x, int unsigned y,
                                   int unsigned w, int unsigned h,
                                   logic [31:0] c, logic l);
    cmd.kind   = k;
    cmd.pos_x  = COORD_W'(x);
    cmd.pos_y  = COORD_W'(y);
    cmd.width  = SIZE_W'(w);
    cmd.height = SIZE_W'(h);
    cmd.color  = c;
    cmd.last   = l;
    got        = 1'b1;
  endfunction

  // Gather one little-endian pixel byte; true once the pixel is complete
  function automatic bit add_pixel_byte(logic [7:0] b);
    int unsigned need;
    need = (cfg_bpp == 0) ? 1 : ((cfg_bpp > 4) ? 4 : 32'(cfg_bpp));
    pix_acc = pix_acc | (32'(b) << (8 * pix_cnt[1:0]));
    pix_cnt++;
    return pix_cnt >= need;
  endfunction

  // Advance to the next tile; mark the end of the rectangle
  function automatic void finish_tile();
    tile_x += TILE_EDGE;
    phase = PH_FLAGS;
    if (tile_x >= cfg_right) begin
      tile_x = cfg_left;
      tile_y += TILE_EDGE;
      if (tile_y >= cfg_bottom) begin
        phase = PH_STOP;
        if (got) cmd.last = 1'b1;
        else emit_cmd(KIND_DONE, 0, 0, 0, 0, '0, 1'b1);
      end
    end
  endfunction

  function automatic void flag_error(hts_kind_e k);
    phase = PH_STOP;
    emit_cmd(k, tile_x, tile_y, tile_w, tile_h, '0, 1'b1);
  endfunction

  function automatic void after_foreground();
    if (tile_flags[FLAG_ANYSUB]) phase = PH_COUNT;
    else if (!bg_seen) flag_error(KIND_NO_BG);
    else finish_tile();
  endfunction

  function automatic void after_background();
    if (tile_flags[FLAG_FG]) begin
      phase = PH_FG;
      clear_pixel();
    end else begin
      after_foreground();
    end
  endfunction

  function automatic void next_subrect();
    clear_pixel();
    if (tile_flags[FLAG_COLORED] && !tile_flags[FLAG_FG]) phase = PH_SUBCOL;
    else phase = PH_SUBXY;
  endfunction

  // Work out the command, if any, that one accepted byte causes
  function automatic void decode_byte(logic [7:0] b);
    int unsigned edge_r, edge_b;
    got = 1'b0;
    case (phase)
      PH_FLAGS: begin
        if (cfg_left >= cfg_right || cfg_top >= cfg_bottom) begin
          phase = PH_STOP;
          emit_cmd(KIND_DONE, 0, 0, 0, 0, '0, 1'b1);
        end else begin
          edge_r = tile_x + TILE_EDGE;
          if (edge_r > cfg_right) edge_r = cfg_right;
          edge_b = tile_y + TILE_EDGE;
          if (edge_b > cfg_bottom) edge_b = cfg_bottom;
          tile_w = edge_r - tile_x;
          tile_h = edge_b - tile_y;
          if (edge_r > frame_cap(cfg_frame_w) || edge_b > frame_cap(cfg_frame_h)) begin
            flag_error(KIND_OUTSIDE);
          end else begin
            tile_flags = b;
            clear_pixel();
            if (b[FLAG_RAW]) begin
              raw_col = 0;
              raw_row = 0;
              phase   = PH_RAW;
            end else if (b[FLAG_BG]) begin
              phase = PH_BG;
            end else begin
              if (bg_seen) emit_cmd(KIND_FILL, tile_x, tile_y, tile_w, tile_h, background, 1'b0);
              after_background();
            end
          end
        end
      end
      PH_RAW: begin
        if (add_pixel_byte(b)) begin
          emit_cmd(KIND_PIXEL, tile_x + raw_col, tile_y + raw_row, 1, 1, pix_acc, 1'b0);
          clear_pixel();
          raw_col++;
          if (raw_col >= tile_w) begin
            raw_col = 0;
            raw_row++;
            if (raw_row >= tile_h) finish_tile();
          end
        end
      end
      PH_BG: begin
        if (add_pixel_byte(b)) begin
          background = pix_acc;
          bg_seen    = 1'b1;
          clear_pixel();
          emit_cmd(KIND_FILL, tile_x, tile_y, tile_w, tile_h, background, 1'b0);
          after_background();
        end
      end
      PH_FG: begin
        if (add_pixel_byte(b)) begin
          foreground = pix_acc;
          clear_pixel();
          after_foreground();
        end
      end
      PH_COUNT: begin
        subs_left = 32'(b);
        if (subs_left == 0) finish_tile();
        else next_subrect();
      end
      PH_SUBCOL: begin
        if (add_pixel_byte(b)) begin
          foreground = pix_acc;
          clear_pixel();
          phase = PH_SUBXY;
        end
      end
      PH_SUBXY: begin
        sub_xy = b;
        phase  = PH_SUBWH;
      end
      PH_SUBWH: begin
        emit_cmd(KIND_FILL, tile_x + 32'(sub_xy[7:4]), tile_y + 32'(sub_xy[3:0]),
                 32'(b[7:4]) + 1, 32'(b[3:0]) + 1, foreground, 1'b0);
        subs_left--;
        if (subs_left == 0) finish_tile();
        else next_subrect();
      end
      default: ;
    endcase
    if (got) pending_cmds.push_back(cmd);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one byte, wait for the transfer, then predict its command
  task automatic send_byte(input logic [7:0] b);
    int n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      repeat (n) begin
        @(negedge clk_i);
        push          <= 1'b0;
        stream_byte_i <= 8'($urandom_range(0, 255));
      end
    end
    @(negedge clk_i);
    push          <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_byte(b);
    byte_cnt++;
  endtask

  task automatic send_bytes(input byte_list_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stop offering, wait for every expected command, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    // Mirror the write; any real register rearms the decoder
    case (idx)
      REG_BPP:     cfg_bpp     = data[BPP_W-1:0];
      REG_FRAME_W: cfg_frame_w = 32'(data);
      REG_FRAME_H: cfg_frame_h = 32'(data);
      REG_RECT_L:  cfg_left    = 32'(data[EDGE_W-1:0]);
      REG_RECT_T:  cfg_top     = 32'(data[EDGE_W-1:0]);
      REG_RECT_R:  cfg_right   = 32'(data);
      REG_RECT_B:  cfg_bottom  = 32'(data);
      default: ;
    endcase
    if (idx < NUM_REGS) rearm();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_rect(input int unsigned bpp, input int unsigned fw, input int unsigned fh,
                          input int unsigned left, input int unsigned top,
                          input int unsigned right, input int unsigned bottom);
    settle();
    write_reg(REG_BPP, bpp);
    write_reg(REG_FRAME_W, fw);
    write_reg(REG_FRAME_H, fh);
    write_reg(REG_RECT_L, left);
    write_reg(REG_RECT_T, top);
    write_reg(REG_RECT_R, right);
    write_reg(REG_RECT_B, bottom);
    rect_cnt++;
  endtask

  // Random byte shaped by what the decoder expects next
  function automatic logic [7:0] pick_stream_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    case (phase)
      PH_FLAGS: if ($urandom_range(0, 5) != 0) v[FLAG_RAW] = 1'b0;
      PH_COUNT: if ($urandom_range(0, 59) != 0) v = 8'($urandom_range(0, 5));
      default: ;
    endcase
    return v;
  endfunction

  // Result side: random stalls, plus a long hold on request
  initial begin
    int n;
    pop = 1'b0;
    forever begin
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        repeat (n) begin
          @(negedge clk_i);
          pop <= 1'b0;
        end
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 11);
        repeat (n) begin
          @(negedge clk_i);
          pop <= 1'b0;
        end
      end else begin
        @(negedge clk_i);
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      err_cnt++;
    end
  endfunction

  // Compare each result transfer with the oldest pending command
  always @(posedge clk_i) begin : check_results
    hts_res_t want;
    if (rst_ni && pop && !empty) begin
      kind_hits[kind_o]++;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d at (%0d,%0d)",
                 $time, kind_o, pos_x_o, pos_y_o);
        err_cnt++;
      end else begin
        want = pending_cmds.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(kind_o));
        cmp_field("pos_x", 32'(want.pos_x), 32'(pos_x_o));
        cmp_field("pos_y", 32'(want.pos_y), 32'(pos_y_o));
        cmp_field("fill_width", 32'(want.width), 32'(fill_width_o));
        cmp_field("fill_height", 32'(want.height), 32'(fill_height_o));
        cmp_field("color", want.color, color_o);
        cmp_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: 4-byte pixels, one 16x16 tile at the origin
  task automatic test_reset_defaults();
    send_bytes('{8'h0A, 8'h11, 8'h22, 8'h33, 8'h44, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00});
    // decoder is stopped now, so this byte must be dropped
    send_byte(8'hA5);
  endtask

  // Raw tiles, raw flag over all others, out-of-range pixel sizes
  task automatic test_raw_tiles();
    set_rect(0, MAX_FRAME, MAX_FRAME, 0, 0, 2, 2);
    send_bytes('{8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF});
    set_rect(7, MAX_FRAME, MAX_FRAME, 4080, 4080, 4081, 4081);
    send_bytes('{8'h01, 8'hEF, 8'hBE, 8'hAD, 8'hDE});
  endtask

  // Colored subrects, inherited foreground, foreground over colored
  task automatic test_subrect_colors();
    set_rect(2, MAX_FRAME, MAX_FRAME, 8, 5, 56, 21);
    send_bytes('{8'h1A, 8'h34, 8'h12, 8'h02, 8'h78, 8'h56, 8'h3C, 8'h21,
                 8'hCD, 8'hAB, 8'hF0, 8'h0F});
    send_bytes('{8'h08, 8'h01, 8'h11, 8'h11});
    send_bytes('{8'h1C, 8'hEF, 8'hBE, 8'h01, 8'h00, 8'hFF});
  endtask

  // Zero subrect count, and a flags-only tile reusing the background
  task automatic test_tile_endings();
    set_rect(1, MAX_FRAME, MAX_FRAME, 0, 0, 32, 16);
    send_bytes('{8'h0A, 8'h5A, 8'h00, 8'h00});
  endtask

  task automatic test_error_cases();
    // no background, with and without foreground bytes
    set_rect(1, MAX_FRAME, MAX_FRAME, 0, 0, 16, 16);
    send_byte(8'h00);
    set_rect(1, MAX_FRAME, MAX_FRAME, 0, 0, 16, 16);
    send_bytes('{8'h04, 8'h99});
    // tile past the frame edge, then an exact fit
    set_rect(1, 10, MAX_FRAME, 0, 0, 16, 16);
    send_byte(8'h02);
    set_rect(1, 16, 15, 0, 0, 16, 16);
    send_byte(8'h02);
    set_rect(1, 16, 16, 0, 0, 16, 16);
    send_bytes('{8'h02, 8'h42});
    // frame size saturates at the maximum
    set_rect(1, 8191, 8191, 4090, 0, 4100, 16);
    send_byte(8'h02);
    set_rect(1, 8191, 8191, 4080, 4080, 4096, 4096);
    send_bytes('{8'h02, 8'h24});
    set_rect(1, MAX_FRAME, MAX_FRAME, 4095, 4095, 8191, 8191);
    send_byte(8'h00);
    // empty rectangle; the unused index must not rearm
    set_rect(1, MAX_FRAME, MAX_FRAME, 20, 0, 20, 16);
    send_byte(8'h55);
    settle();
    write_reg(REG_UNUSED, 13'h1FFF);
    send_byte(8'h02);
    set_rect(1, MAX_FRAME, MAX_FRAME, 0, 9, 16, 0);
    send_byte(8'h00);
    // left edge keeps only its low twelve bits
    set_rect(1, MAX_FRAME, MAX_FRAME, 13'h1005, 0, 8, 1);
    send_bytes('{8'h02, 8'h77});
  endtask

  // Fill the block while results are held, then pause mid-rectangle
  task automatic test_backpressure();
    idle_on = 1'b0;
    set_rect(1, MAX_FRAME, MAX_FRAME, 0, 0, 16, 8);
    rx_hold_len = 80;
    send_byte(8'h01);
    repeat (60) send_byte(8'($urandom_range(0, 255)));
    settle();
    repeat (68) send_byte(8'($urandom_range(0, 255)));
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int sent;
    int unsigned bpp, fw, fh, left, top, w, h;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      // quiet finish: no idling on either side
      if (sent > RANDOM_BYTES - 250) idle_on = 1'b0;
      bpp = $urandom_range(0, 11);
      if (bpp > 9) bpp = 2;
      else if (bpp > 7) bpp = 1;
      fw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : MAX_FRAME;
      fh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : MAX_FRAME;
      left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      top  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
      w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
      set_rect(bpp, fw, fh, left, top, left + w, top + h);
      while (phase != PH_STOP) begin
        send_byte(pick_stream_byte());
        sent++;
      end
      // stray byte while stopped
      if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    stream_byte_i = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    idle_on       = 1'b1;
    rx_hold_len   = 0;
    err_cnt       = 0;
    rect_cnt      = 0;
    byte_cnt      = 0;
    cfg_bpp       = BPP_RST;
    cfg_frame_w   = 32'(FRAME_W_RST);
    cfg_frame_h   = 32'(FRAME_H_RST);
    cfg_left      = 32'(RECT_L_RST);
    cfg_top       = 32'(RECT_T_RST);
    cfg_right     = 32'(RECT_R_RST);
    cfg_bottom    = 32'(RECT_B_RST);
    rearm();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_raw_tiles();
    test_subrect_colors();
    test_tile_endings();
    test_error_cases();
    test_backpressure();
    test_random_stream();
    settle();

    $display("Covered %0d stream bytes over %0d rectangle setups.", byte_cnt, rect_cnt);
    $display("Results seen: %0d fills, %0d pixels, %0d done, %0d outside, %0d no-background.",
             kind_hits[KIND_FILL], kind_hits[KIND_PIXEL], kind_hits[KIND_DONE],
             kind_hits[KIND_OUTSIDE], kind_hits[KIND_NO_BG]);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("%0t: timeout, %0d commands still pending", $time, pending_cmds.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
